[rtl/escape_time_gradient_colorizer_top_macros.svh]
// Assertion macros used by the colorizer's checker file.
`ifndef ESCAPE_TIME_GRADIENT_COLORIZER_TOP_MACROS_SVH
`define ESCAPE_TIME_GRADIENT_COLORIZER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETGC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ETGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/etgc_pkg.sv]
// Shared constants and types of the escape-time gradient colorizer.
package etgc_pkg;

  localparam int ITER_BITS_DEF = 16;
  localparam int LIMIT_BITS    = 16;
  localparam int LANES         = 3;
  localparam int CHAN_BITS     = 8;
  localparam int COLOR_BITS    = 32;
  localparam int MODE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [CHAN_BITS-1:0] chan_t;

  localparam chan_t CHAN_MAX = 8'hFF;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_COLOR    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_GRADIENT_MODE = CFG_IDX_BITS'(2);

  // Gradient modes: pivot shade and escape color.
  localparam logic [MODE_BITS-1:0] MODE_DARK_BLACK  = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_LIGHT_WHITE = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_DARK_WHITE  = MODE_BITS'(2);
  localparam logic [MODE_BITS-1:0] MODE_LIGHT_BLACK = MODE_BITS'(3);

  localparam logic [LIMIT_BITS-1:0] ITER_LIMIT_RST = LIMIT_BITS'(64);

  // Slopes carry three decimal digits of fraction.
  localparam int SLOPE_SCALE = 1000;
  // Numerator is at most 255 * 1000, which fits in 18 bits.
  localparam int NUM_BITS    = 18;
  localparam int QBITS       = NUM_BITS;
  // Slope times count stays below 2^20 in every branch that uses it.
  localparam int PROD_BITS   = 20;

  // floor(x / 1000) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^20.
  localparam int                   RECIP_SHIFT = 30;
  localparam int                   RECIP_BITS  = 21;
  localparam logic [RECIP_BITS-1:0] RECIP      = RECIP_BITS'(1073742);

  // Register stages that can hold an item: input, setup, quotient steps,
  // two multiply stages, grading, output and skid.
  localparam int PIPE_DEPTH = QBITS + 7;

endpackage

[rtl/escape_time_gradient_colorizer_top.sv]
// Top level of the escape-time gradient colorizer.
//
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    in_iter_count
// out      out  out_valid/out_ready  out_pixel_color
// cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One pixel is taken per clock while in_ready is high. Results pass the
// input, setup, 18-step quotient (slope), multiply, scale, grading and output
// registers. Reset is synchronous and active low; it clears the valid bits,
// empties the output and skid registers and loads the register defaults. A
// stall on the output fills the skid register; in_ready then drops and the
// whole pipeline holds until the skid register drains.
module escape_time_gradient_colorizer_top #(
  parameter int ITER_BITS = etgc_pkg::ITER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ITER_BITS-1:0]                 in_iter_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [etgc_pkg::COLOR_BITS-1:0]      out_pixel_color,
  input  logic                                 cfg_we,
  input  logic [etgc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [etgc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import etgc_pkg::*;

  localparam int HALF_BITS  = ITER_BITS - 1;
  localparam int LIM_KEEP   = (ITER_BITS < LIMIT_BITS) ? ITER_BITS : LIMIT_BITS;
  localparam int MUL_BITS   = QBITS + ITER_BITS;
  localparam int SCALE_BITS = PROD_BITS + RECIP_BITS;

  // What travels beside the quotient pipeline for each item.
  typedef struct packed {
    logic                 valid;
    logic [ITER_BITS-1:0] it;
    logic                 below;     // count is under the pivot
    logic                 at_pivot;  // count equals the pivot
    logic                 in_range;  // count is under the limit
  } side_t;

  // Configuration registers. The user must change them only while no transfer
  // is in flight (not enforced here); every stage reads them directly.
  logic [LIMIT_BITS-1:0] iter_limit_r;
  logic [COLOR_BITS-1:0] base_color_r;
  logic [MODE_BITS-1:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r <= ITER_LIMIT_RST;
      base_color_r <= '0;
      mode_r       <= MODE_DARK_BLACK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ITER_LIMIT:    iter_limit_r <= cfg_wdata[LIMIT_BITS-1:0];
        REG_BASE_COLOR:    base_color_r <= cfg_wdata[COLOR_BITS-1:0];
        REG_GRADIENT_MODE: mode_r       <= cfg_wdata[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [ITER_BITS-1:0] lim;
  logic [HALF_BITS-1:0] half;
  logic                 odd;
  logic                 esc_white;

  assign lim       = ITER_BITS'(iter_limit_r[LIM_KEEP-1:0]);
  assign half      = lim[ITER_BITS-1:1];
  assign odd       = mode_r[0];
  assign esc_white = (mode_r == MODE_LIGHT_WHITE) || (mode_r == MODE_DARK_WHITE);

  // The pipeline moves as one while the skid register is empty.
  logic pipe_en;
  logic skid_valid_r;

  assign pipe_en  = !skid_valid_r;
  assign in_ready = pipe_en;

  // Stage 0: capture the count.
  logic                 s0_valid_r;
  logic [ITER_BITS-1:0] s0_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s0_it_r <= in_iter_count;
    end
  end

  // Stage 1: find the region against the pivot and the limit, then form
  // each channel's slope numerator. Below the pivot the odd modes climb by
  // the channel value and the even modes fall by its inverse; above the
  // pivot the roles swap, so one magnitude per channel serves both.
  side_t                          s1_side_nxt;
  side_t                          s1_side_r;
  logic [LANES-1:0][NUM_BITS-1:0] s1_num_nxt;
  logic [LANES-1:0][NUM_BITS-1:0] s1_num_r;

  always_comb begin
    chan_t c;
    chan_t sel;
    s1_side_nxt.valid    = s0_valid_r;
    s1_side_nxt.it       = s0_it_r;
    s1_side_nxt.below    = (s0_it_r < ITER_BITS'(half));
    s1_side_nxt.at_pivot = (s0_it_r == ITER_BITS'(half));
    s1_side_nxt.in_range = (s0_it_r < lim);
    for (int l = 0; l < LANES; l++) begin
      c   = base_color_r[l*CHAN_BITS +: CHAN_BITS];
      sel = (odd ^ !s1_side_nxt.below) ? c : ~c;
      s1_num_nxt[l] = NUM_BITS'(sel) * NUM_BITS'(SLOPE_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
    end else if (pipe_en) begin
      s1_side_r <= s1_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_num_r <= s1_num_nxt;
    end
  end

  // Quotient pipeline: slope magnitude = numerator / pivot, truncated.
  // The side data runs alongside it, one register per quotient step.
  logic [LANES-1:0][QBITS-1:0] quo;
  side_t                       side_r [QBITS];

  etgc_divider #(
    .DEN_BITS (HALF_BITS)
  ) u_div (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (s1_num_r),
    .den_i (half),
    .quo_o (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QBITS; k++) begin
        side_r[k].valid <= 1'b0;
      end
    end else if (pipe_en) begin
      side_r[0] <= s1_side_r;
      for (int k = 1; k < QBITS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Stage M: slope times count and slope times limit. Both products stay
  // below 2^20 whenever the grading uses them, so the low bits suffice.
  logic [LANES-1:0][MUL_BITS-1:0]  mul_it;
  logic [LANES-1:0][MUL_BITS-1:0]  mul_lim;
  side_t                           sm_side_r;
  logic [LANES-1:0][PROD_BITS-1:0] sm_p1_r;
  logic [LANES-1:0][PROD_BITS-1:0] sm_p2_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mul_it[l]  = MUL_BITS'(quo[l]) * MUL_BITS'(side_r[QBITS-1].it);
      mul_lim[l] = MUL_BITS'(quo[l]) * MUL_BITS'(lim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_side_r.valid <= 1'b0;
    end else if (pipe_en) begin
      sm_side_r <= side_r[QBITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int l = 0; l < LANES; l++) begin
        sm_p1_r[l] <= mul_it[l][PROD_BITS-1:0];
        sm_p2_r[l] <= mul_lim[l][PROD_BITS-1:0];
      end
    end
  end

  // Stage R: divide both products by 1000 through the reciprocal. Only the
  // low byte of each quotient matters, since the result wraps to 8 bits.
  logic [LANES-1:0][SCALE_BITS-1:0] scale_1;
  logic [LANES-1:0][SCALE_BITS-1:0] scale_2;
  side_t                            sr_side_r;
  logic [LANES-1:0][CHAN_BITS-1:0]  sr_p1_r;
  logic [LANES-1:0][CHAN_BITS-1:0]  sr_p2_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      scale_1[l] = SCALE_BITS'(sm_p1_r[l]) * SCALE_BITS'(RECIP);
      scale_2[l] = SCALE_BITS'(sm_p2_r[l]) * SCALE_BITS'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_side_r.valid <= 1'b0;
    end else if (pipe_en) begin
      sr_side_r <= sm_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int l = 0; l < LANES; l++) begin
        sr_p1_r[l] <= scale_1[l][RECIP_SHIFT +: CHAN_BITS];
        sr_p2_r[l] <= scale_2[l][RECIP_SHIFT +: CHAN_BITS];
      end
    end
  end

  // Stage F: grade each channel in 8-bit wrapping arithmetic. With p1 the
  // scaled count term and p2 the scaled limit term:
  //   below the pivot   odd: inv + p1          even: inv - p1
  //   at the pivot      odd: white             even: black
  //   up to the limit   odd: c + p2 - p1       even: p1 - c
  //   at or past limit  escape color of the mode
  logic [LANES-1:0][CHAN_BITS-1:0] grade;
  logic                            sf_valid_r;
  logic [COLOR_BITS-1:0]           sf_color_r;

  always_comb begin
    chan_t c;
    chan_t inv;
    for (int l = 0; l < LANES; l++) begin
      c   = base_color_r[l*CHAN_BITS +: CHAN_BITS];
      inv = ~c;
      priority if (sr_side_r.below) begin
        grade[l] = odd ? chan_t'(inv + sr_p1_r[l]) : chan_t'(inv - sr_p1_r[l]);
      end else if (sr_side_r.at_pivot) begin
        grade[l] = odd ? CHAN_MAX : '0;
      end else if (sr_side_r.in_range) begin
        grade[l] = odd ? chan_t'(c + sr_p2_r[l] - sr_p1_r[l])
                       : chan_t'(sr_p1_r[l] - c);
      end else begin
        grade[l] = esc_white ? CHAN_MAX : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_valid_r <= 1'b0;
    end else if (pipe_en) begin
      sf_valid_r <= sr_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sf_color_r <= {base_color_r[COLOR_BITS-1 -: CHAN_BITS], grade};
    end
  end

  // Output register with a skid register behind it. The skid register
  // catches the item leaving stage F when the output is stalled, so
  // in_ready comes straight from a flop and never from out_ready.
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  skid_valid_nxt;
  logic                  out_load_pipe;
  logic                  out_load_skid;
  logic                  skid_load;
  logic [COLOR_BITS-1:0] out_color_r;
  logic [COLOR_BITS-1:0] skid_color_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load_pipe  = 1'b0;
    out_load_skid  = 1'b0;
    skid_load      = 1'b0;
    priority if (skid_valid_r) begin
      if (out_ready) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
        out_load_skid  = 1'b1;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_nxt = sf_valid_r;
      out_load_pipe = 1'b1;
    end else if (sf_valid_r) begin
      skid_valid_nxt = 1'b1;
      skid_load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_skid) begin
      out_color_r <= skid_color_r;
    end else if (out_load_pipe) begin
      out_color_r <= sf_color_r;
    end
    if (skid_load) begin
      skid_color_r <= sf_color_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

endmodule

[rtl/etgc_divider.sv]
// Pipelined restoring divider, one quotient bit per stage for each color lane.
module etgc_divider #(
  parameter int DEN_BITS = etgc_pkg::ITER_BITS_DEF - 1
) (
  input  logic                                                    clk,
  input  logic                                                    en,
  input  logic [etgc_pkg::LANES-1:0][etgc_pkg::NUM_BITS-1:0]      num_i,
  input  logic [DEN_BITS-1:0]                                     den_i,
  output logic [etgc_pkg::LANES-1:0][etgc_pkg::QBITS-1:0]         quo_o
);
  import etgc_pkg::*;

  logic [LANES-1:0][DEN_BITS-1:0] rem_r [QBITS-1];
  logic [LANES-1:0][NUM_BITS-1:0] num_r [QBITS-1];
  logic [LANES-1:0][QBITS-1:0]    quo_r [QBITS];

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic [LANES-1:0][DEN_BITS-1:0] rem_in;
    logic [LANES-1:0][NUM_BITS-1:0] num_in;
    logic [LANES-1:0][QBITS-1:0]    quo_in;
    logic [LANES-1:0][DEN_BITS:0]   trial;
    logic [LANES-1:0]               qbit;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_in[l], num_in[l][NUM_BITS-1]};
        qbit[l]  = (trial[l] >= {1'b0, den_i});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          quo_r[s][l] <= {quo_in[l][QBITS-2:0], qbit[l]};
        end
      end
    end

    // The last step needs no partial remainder or numerator afterwards.
    if (s < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < LANES; l++) begin
            rem_r[s][l] <= qbit[l] ? DEN_BITS'(trial[l] - {1'b0, den_i})
                                   : trial[l][DEN_BITS-1:0];
            num_r[s][l] <= {num_in[l][NUM_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign quo_o = quo_r[QBITS-1];

endmodule

[rtl/etgc_checker.sv]
// Port-level checker of the colorizer and its bind to the top level.
`include "escape_time_gradient_colorizer_top_macros.svh"

module etgc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [etgc_pkg::COLOR_BITS-1:0] out_pixel_color
);
  import etgc_pkg::*;

  localparam int CNT_BITS = $clog2(PIPE_DEPTH + 1) + 1;

  logic [CNT_BITS-1:0] pend_r;
  logic [CNT_BITS-1:0] pend_nxt;
  logic                in_xfer;
  logic                out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + CNT_BITS'(1);
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A result is only offered for a pixel that was taken earlier.
  `ETGC_ASSERT_NOW(a_out_has_source, clk, rst_n, out_valid, pend_r != '0)
  // No more pixels are in flight than the pipeline has places.
  `ETGC_ASSERT_NOW(a_pend_bounded, clk, rst_n, 1'b1, pend_r <= CNT_BITS'(PIPE_DEPTH))
  // Input back-pressure only ever comes from a waiting result.
  `ETGC_ASSERT_NOW(a_stall_from_output, clk, rst_n, !in_ready, out_valid)
  // A stalled result stays offered and unchanged.
  `ETGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel_color))

endmodule

bind escape_time_gradient_colorizer_top etgc_checker u_etgc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_color (out_pixel_color)
);
